@@ hdl/pds_pkg.sv @@
// shared types and constants for the particle depth sorter
package pds_pkg;

    localparam int CoordBits = 24;
    localparam int IndexBits = 6;

    typedef struct packed {
        logic [CoordBits-1:0] pos_x;
        logic [CoordBits-1:0] pos_y;
        logic [CoordBits-1:0] pos_z;
        logic                 last_in;
    } pds_in_t;

    typedef struct packed {
        logic [IndexBits-1:0] sorted_index;
        logic                 last_out;
        logic                 overflow;
    } pds_out_t;

    typedef enum logic [1:0] {
        REG_REF_X = 2'd0,
        REG_REF_Y = 2'd1,
        REG_REF_Z = 2'd2
    } pds_reg_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // compute key of the input beat
        logic insert;    // insertion step at scan position
        logic drop;      // set is full, mark overflow
        logic emit_load; // register output beat at read position
        logic clear;     // run done, reset fill count and flag
    } pds_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } pds_sts_t;

endpackage

@@ hdl/particle_depth_sorter.sv @@
// top level of the particle depth sorter
// key: diff, square and sum registers lie between an accepted beat and its insertion
// input: one insertion per beat not dropped on a full set; a new beat waits for that insertion
// output: one sorted index per cycle while m_ready stays high, after the last beat
// reset: aresetn synchronous active low, clears reference point, fill count, flag and control; stores keep
module particle_depth_sorter #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [pds_pkg::CoordBits-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  pds_pkg::pds_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pds_pkg::pds_out_t  m_data
);
    import pds_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    logic [CoordBits-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    pds_cmd_t cmd;
    pds_sts_t sts;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] fill;

    // reference point registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_REF_X: ref_x_reg <= cfg_data;
                REG_REF_Y: ref_y_reg <= cfg_data;
                REG_REF_Z: ref_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pds_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .last_in(s_data.last_in),
        .m_valid, .m_ready, .sts, .fill, .cmd, .rd_addr
    );

    pds_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
        .aclk, .aresetn, .ref_x(ref_x_reg), .ref_y(ref_y_reg), .ref_z(ref_z_reg),
        .in_beat(s_data), .cmd, .rd_addr, .sts, .fill, .out_beat(m_data)
    );
endmodule

@@ hdl/pds_datapath.sv @@
// key computation, sorted stores and output read
module pds_datapath #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pds_pkg::CoordBits-1:0] ref_x,
    input  logic [pds_pkg::CoordBits-1:0] ref_y,
    input  logic [pds_pkg::CoordBits-1:0] ref_z,
    input  pds_pkg::pds_in_t          in_beat,
    input  pds_pkg::pds_cmd_t         cmd,
    input  logic [$clog2(MAX_PARTICLES)-1:0] rd_addr,
    output pds_pkg::pds_sts_t         sts,
    output logic [$clog2(MAX_PARTICLES+1)-1:0] fill,
    output pds_pkg::pds_out_t         out_beat
);
    import pds_pkg::*;

    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int DW = CoordBits + 1;
    localparam int KW = 2 * CoordBits + 2;

    logic [KW-1:0]        key_store [MAX_PARTICLES];
    logic [IndexBits-1:0] index_store [MAX_PARTICLES];
    logic [CW-1:0]        fill_reg;
    logic                 drop_reg;
    logic [DW-1:0]        dx_reg, dy_reg, dz_reg;
    logic [2*DW-1:0]      sx_reg, sy_reg, sz_reg;
    logic [KW-1:0]        key_reg;
    logic [IndexBits-1:0] idx_reg;
    pds_out_t             out_reg;

    function automatic logic [DW-1:0] absdiff(input logic [CoordBits-1:0] a,
                                              input logic [CoordBits-1:0] b);
        logic signed [DW-1:0] d;
        d = DW'($signed(a)) - DW'($signed(b));
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    // key pipeline: diff, square, sum (driven by load pulses spaced by controller)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dx_reg <= absdiff(in_beat.pos_x, ref_x);
            dy_reg <= absdiff(in_beat.pos_y, ref_y);
            dz_reg <= absdiff(in_beat.pos_z, ref_z);
            idx_reg <= IndexBits'(fill_reg);
        end
        sx_reg  <= dx_reg * dx_reg;
        sy_reg  <= dy_reg * dy_reg;
        sz_reg  <= dz_reg * dz_reg;
        key_reg <= KW'(sx_reg) + KW'(sy_reg) + KW'(sz_reg);
    end

    // insertion: each entry compares against new key, shift chain in parallel
    logic [MAX_PARTICLES-1:0] less;
    always_comb begin
        for (int k = 0; k < MAX_PARTICLES; k++) begin
            less[k] = (k < int'(fill_reg)) && (key_store[k] < key_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int k = 0; k < MAX_PARTICLES; k++) begin
                if (k <= int'(fill_reg)) begin
                    if (less[k] && (k == 0 || !less[k-1])) begin
                        key_store[k]   <= key_reg;
                        index_store[k] <= idx_reg;
                    end else if (k > 0 && less[k-1]) begin
                        key_store[k]   <= key_store[k-1];
                        index_store[k] <= index_store[k-1];
                    end else if (k == int'(fill_reg) && (k == 0 || !less[k-1])) begin
                        key_store[k]   <= key_reg;
                        index_store[k] <= idx_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
        end else if (cmd.clear) begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
        end else begin
            if (cmd.insert) fill_reg <= fill_reg + CW'(1);
            if (cmd.drop)   drop_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_reg.sorted_index <= index_store[rd_addr];
            out_reg.last_out     <= (CW'(rd_addr) + CW'(1)) == fill_reg;
            out_reg.overflow     <= drop_reg;
        end
    end

    assign sts.full  = fill_reg == CW'(MAX_PARTICLES);
    assign sts.empty = fill_reg == '0;
    assign fill      = fill_reg;
    assign out_beat  = out_reg;
endmodule

@@ hdl/pds_ctrl.sv @@
// sequencing of load, insert, emit and clear phases
module pds_ctrl #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               last_in,
    output logic               m_valid,
    input  logic               m_ready,
    input  pds_pkg::pds_sts_t  sts,
    input  logic [$clog2(MAX_PARTICLES+1)-1:0] fill,
    output pds_pkg::pds_cmd_t  cmd,
    output logic [$clog2(MAX_PARTICLES)-1:0] rd_addr
);
    import pds_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_D1, S_D2, S_INS, S_EMIT, S_CLEAR
    } state_t;

    state_t        state_reg;
    logic          last_reg, mval_reg;
    logic [AW-1:0] rd_reg;
    logic [CW-1:0] cnt_reg;

    assign s_ready = (state_reg == S_IDLE);
    wire acc = s_valid && s_ready;

    always_comb begin
        cmd = '0;
        cmd.load      = acc && !sts.full;
        cmd.drop      = acc && sts.full;
        cmd.insert    = (state_reg == S_INS);
        cmd.emit_load = (state_reg == S_EMIT) && (!mval_reg || m_ready)
                        && (cnt_reg < fill);
        cmd.clear     = (state_reg == S_CLEAR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            mval_reg  <= 1'b0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cmd.emit_load) mval_reg <= 1'b1;
            else if (m_ready)  mval_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (acc) begin
                    last_reg <= last_in;
                    cnt_reg  <= '0;
                    rd_reg   <= '0;
                    if (!sts.full) state_reg <= S_D1;
                    else if (last_in) state_reg <= sts.empty ? S_CLEAR : S_EMIT;
                end
                S_D1: state_reg <= S_D2;
                S_D2: state_reg <= S_INS;
                S_INS: state_reg <= last_reg ? S_EMIT : S_IDLE;
                S_EMIT: begin
                    if (cmd.emit_load) begin
                        rd_reg   <= rd_reg + AW'(1);
                        cnt_reg  <= cnt_reg + CW'(1);
                    end else if (cnt_reg == fill && (!mval_reg || m_ready)) begin
                        state_reg <= S_CLEAR;
                    end
                end
                S_CLEAR: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = mval_reg;
    assign rd_addr = rd_reg;
endmodule

@@ hdl/pds_checker.sv @@
// port-level checks for the particle depth sorter
module pds_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input pds_pkg::pds_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("beat dropped");
    a_noin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during run");
    a_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_out |=> !m_valid) else $error("beat after last");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
endmodule

bind particle_depth_sorter pds_checker u_chk (.*);
